// ===== rtl/owb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owb_pkg
// Shared types, register indexes and defaults of the one-wire bus master.
// ----------------------------------------------------------------------------
package owb_pkg;

  localparam int TimeW     = 10;  // timing register and tick counter width
  localparam int DataW     = 16;  // shift register / read word width
  localparam int CntW      = 5;   // bits-left counter width
  localparam int WRITE_BITS = 8;
  localparam int ReadBitsDef = 16;

  localparam logic [TimeW-1:0] RstLowDef   = 10'd480;
  localparam logic [TimeW-1:0] RstRelDef   = 10'd480;
  localparam logic [TimeW-1:0] PresSampDef = 10'd60;
  localparam logic [TimeW-1:0] Wr0LowDef   = 10'd60;
  localparam logic [TimeW-1:0] Wr1LowDef   = 10'd5;
  localparam logic [TimeW-1:0] RdLowDef    = 10'd5;
  localparam logic [TimeW-1:0] RdSampDef   = 10'd15;
  localparam logic [TimeW-1:0] SlotLenDef  = 10'd61;

  typedef enum logic [2:0] {
    REG_RESET_LOW   = 3'd0,
    REG_RESET_REL   = 3'd1,
    REG_PRES_SAMPLE = 3'd2,
    REG_WR0_LOW     = 3'd3,
    REG_WR1_LOW     = 3'd4,
    REG_RD_LOW      = 3'd5,
    REG_RD_SAMPLE   = 3'd6,
    REG_SLOT_LEN    = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_RESET = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_RST_LOW = 2'd1,
    PH_RST_REL = 2'd2,
    PH_SLOT    = 2'd3
  } phase_t;

  typedef struct packed {
    logic [TimeW-1:0] reset_low_time;
    logic [TimeW-1:0] reset_release_time;
    logic [TimeW-1:0] presence_sample_time;
    logic [TimeW-1:0] write_zero_low_time;
    logic [TimeW-1:0] write_one_low_time;
    logic [TimeW-1:0] read_low_time;
    logic [TimeW-1:0] read_sample_time;
    logic [TimeW-1:0] slot_length;
  } cfg_t;

  typedef struct packed {
    logic       start_req;
    logic [1:0] func;
    logic [7:0] write_byte;
    logic       line_level;
  } tick_t;

  typedef struct packed {
    logic             drive_low;
    logic             busy_res;
    logic             done_res;
    logic             presence;
    logic [DataW-1:0] read_word;
  } res_t;

endpackage

// ===== rtl/one_wire_bus_master_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_wire_bus_master_top
// One-wire bus master: bus reset with presence detect, byte write, word read.
// ----------------------------------------------------------------------------
// Each tick transaction is one microsecond of bus time and carries the sampled
// line level plus an optional command. The block takes one tick per clock
// cycle while tick_stall is low and returns exactly one result per tick, held
// first in the tick register, then in the result register. The sequencer
// advances its single state set once per tick; the tick register lets one more
// tick in while a result waits. Users write timing registers through the cfg
// port only while no command runs; the block itself does not enforce this.
module one_wire_bus_master_top #(
  parameter int READ_BITS = owb_pkg::ReadBitsDef
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      tick_valid,
  output logic                      tick_stall,
  input  owb_pkg::tick_t            tick,
  output logic                      res_valid,
  input  logic                      res_stall,
  output owb_pkg::res_t             res,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  owb_pkg::reg_idx_t         cfg_index,
  input  logic [owb_pkg::TimeW-1:0] cfg_data
);
  import owb_pkg::*;

  cfg_t  cfg;
  tick_t tick_q;
  logic  tick_q_valid;
  logic  advance;
  res_t  core_res;

  assign cfg_ready  = 1'b1;
  assign advance    = tick_q_valid && (!res_valid || !res_stall);
  assign tick_stall = tick_q_valid && !advance;

  owb_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  owb_core #(
    .READ_BITS (READ_BITS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .tick (tick_q),
    .cfg  (cfg),
    .res  (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_q_valid <= 1'b0;
    end else if (tick_valid && !tick_stall) begin
      tick_q_valid <= 1'b1;
    end else if (advance) begin
      tick_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_valid && !tick_stall) begin
      tick_q <= tick;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= core_res;
    end
  end

  // stall on the tick side only when the result side holds a waiting result
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    tick_stall |-> (tick_q_valid && res_valid && res_stall))
    else $error("tick stall without a full pipe");

  a_done_is_busy: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.done_res) |-> res.busy_res)
    else $error("done outside a command");

  a_idle_no_drive: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.busy_res) |-> !res.drive_low)
    else $error("line driven while idle");

  // an accepted tick is handed to the sequencer in the next cycle or held
  a_tick_moves: assert property (@(posedge clk) disable iff (rst)
    (tick_valid && !tick_stall) |=> tick_q_valid)
    else $error("accepted tick lost");

endmodule

// ===== rtl/owb_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owb_regs
// Timing register file of the one-wire bus master, one write port.
// ----------------------------------------------------------------------------
module owb_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  owb_pkg::reg_idx_t             wr_index,
  input  logic [owb_pkg::TimeW-1:0]     wr_data,
  output owb_pkg::cfg_t                 cfg
);
  import owb_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low_time       <= RstLowDef;
      cfg.reset_release_time   <= RstRelDef;
      cfg.presence_sample_time <= PresSampDef;
      cfg.write_zero_low_time  <= Wr0LowDef;
      cfg.write_one_low_time   <= Wr1LowDef;
      cfg.read_low_time        <= RdLowDef;
      cfg.read_sample_time     <= RdSampDef;
      cfg.slot_length          <= SlotLenDef;
    end else if (wr_en) begin
      case (wr_index)
        REG_RESET_LOW:   cfg.reset_low_time       <= wr_data;
        REG_RESET_REL:   cfg.reset_release_time   <= wr_data;
        REG_PRES_SAMPLE: cfg.presence_sample_time <= wr_data;
        REG_WR0_LOW:     cfg.write_zero_low_time  <= wr_data;
        REG_WR1_LOW:     cfg.write_one_low_time   <= wr_data;
        REG_RD_LOW:      cfg.read_low_time        <= wr_data;
        REG_RD_SAMPLE:   cfg.read_sample_time     <= wr_data;
        REG_SLOT_LEN:    cfg.slot_length          <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/owb_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owb_core
// Bus sequencer: advances reset / write / read slot timing by one tick per step.
// ----------------------------------------------------------------------------
module owb_core #(
  parameter int READ_BITS = owb_pkg::ReadBitsDef
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  owb_pkg::tick_t tick,
  input  owb_pkg::cfg_t  cfg,
  output owb_pkg::res_t  res
);
  import owb_pkg::*;

  localparam int RdShift = DataW - READ_BITS;

  phase_t           phase, phase_next, ph_eff;
  op_t              operation, operation_next, op_eff;
  logic [TimeW-1:0] time_count, time_count_next, tc_eff;
  logic [CntW-1:0]  bits_left, bits_left_next, bl_eff;
  logic [DataW-1:0] shift_word, shift_word_next, sw_eff, sw_samp;
  logic             presence_flag, presence_flag_next, pres_eff;
  logic [DataW-1:0] held_word, held_word_next;

  logic             start_ok;
  logic [TimeW:0]   tc_inc;
  logic [TimeW-1:0] rst_low_eff, rst_rel_eff, slot_len, low_time, samp_at;
  logic             rst_low_end, rst_rel_end, slot_last, slot_drive;
  logic             samp_in_slot, samp_now, samp_bit, pres_hit, last_bit;

  assign start_ok = (phase == PH_IDLE) && tick.start_req &&
                    ((tick.func == OP_RESET) || (tick.func == OP_WRITE) ||
                     (tick.func == OP_READ));

  // a command starts on its own tick
  always_comb begin
    ph_eff   = phase;
    op_eff   = operation;
    tc_eff   = time_count;
    bl_eff   = bits_left;
    sw_eff   = shift_word;
    pres_eff = presence_flag;
    if (start_ok) begin
      op_eff = op_t'(tick.func);
      tc_eff = '0;
      if (tick.func == OP_RESET) begin
        ph_eff   = PH_RST_LOW;
        pres_eff = 1'b0;
      end else if (tick.func == OP_WRITE) begin
        ph_eff = PH_SLOT;
        bl_eff = CntW'(WRITE_BITS);
        sw_eff = DataW'(tick.write_byte);
      end else begin
        ph_eff = PH_SLOT;
        bl_eff = CntW'(READ_BITS);
        sw_eff = '0;
      end
    end
  end

  assign tc_inc      = {1'b0, tc_eff} + 1'b1;
  assign rst_low_eff = (cfg.reset_low_time == '0) ? TimeW'(1) : cfg.reset_low_time;
  assign rst_rel_eff = (cfg.reset_release_time == '0) ? TimeW'(1) : cfg.reset_release_time;
  assign slot_len    = (cfg.slot_length < TimeW'(2)) ? TimeW'(2) : cfg.slot_length;
  assign rst_low_end = tc_inc >= {1'b0, rst_low_eff};
  assign rst_rel_end = tc_inc >= {1'b0, rst_rel_eff};
  assign slot_last   = tc_inc >= {1'b0, slot_len};
  assign pres_hit    = tc_eff == cfg.presence_sample_time;
  assign last_bit    = bl_eff <= CntW'(1);

  assign low_time   = (op_eff == OP_WRITE) ?
                      (sw_eff[0] ? cfg.write_one_low_time : cfg.write_zero_low_time) :
                      cfg.read_low_time;
  assign slot_drive = tc_eff < low_time;

  // late sample point falls back to the last slot tick with a zero bit
  assign samp_in_slot = cfg.read_sample_time < slot_len;
  assign samp_at      = samp_in_slot ? cfg.read_sample_time : slot_len - TimeW'(1);
  assign samp_now     = (op_eff != OP_WRITE) && (tc_eff == samp_at);
  assign samp_bit     = samp_in_slot & tick.line_level;
  assign sw_samp      = samp_now ? {samp_bit, sw_eff[DataW-1:1]} : sw_eff;

  // next state
  always_comb begin
    phase_next         = ph_eff;
    operation_next     = op_eff;
    time_count_next    = tc_eff;
    bits_left_next     = bl_eff;
    shift_word_next    = sw_eff;
    presence_flag_next = pres_eff;
    held_word_next     = held_word;
    case (ph_eff)
      PH_RST_LOW: begin
        if (rst_low_end) begin
          phase_next      = PH_RST_REL;
          time_count_next = '0;
        end else begin
          time_count_next = tc_inc[TimeW-1:0];
        end
      end
      PH_RST_REL: begin
        if (pres_hit) begin
          presence_flag_next = ~tick.line_level;
        end
        if (rst_rel_end) begin
          phase_next      = PH_IDLE;
          time_count_next = '0;
        end else begin
          time_count_next = tc_inc[TimeW-1:0];
        end
      end
      PH_SLOT: begin
        shift_word_next = sw_samp;
        if (slot_last) begin
          time_count_next = '0;
          if (op_eff == OP_WRITE) begin
            shift_word_next = {1'b0, sw_samp[DataW-1:1]};
          end
          if (last_bit) begin
            bits_left_next = '0;
            phase_next     = PH_IDLE;
            if (op_eff != OP_WRITE) begin
              held_word_next = sw_samp >> RdShift;
            end
          end else begin
            bits_left_next = bl_eff - CntW'(1);
          end
        end else begin
          time_count_next = tc_inc[TimeW-1:0];
        end
      end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    res           = '0;
    res.presence  = presence_flag_next;
    res.read_word = held_word_next;
    case (ph_eff)
      PH_RST_LOW: begin
        res.busy_res  = 1'b1;
        res.drive_low = 1'b1;
      end
      PH_RST_REL: begin
        res.busy_res = 1'b1;
        res.done_res = rst_rel_end;
      end
      PH_SLOT: begin
        res.busy_res  = 1'b1;
        res.drive_low = slot_drive;
        res.done_res  = slot_last && last_bit;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      operation     <= OP_RESET;
      time_count    <= '0;
      bits_left     <= '0;
      shift_word    <= '0;
      presence_flag <= 1'b0;
      held_word     <= '0;
    end else if (step) begin
      phase         <= phase_next;
      operation     <= operation_next;
      time_count    <= time_count_next;
      bits_left     <= bits_left_next;
      shift_word    <= shift_word_next;
      presence_flag <= presence_flag_next;
      held_word     <= held_word_next;
    end
  end

endmodule

// ===== verif/tb_one_wire_bus_master_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_one_wire_bus_master_top
// Self-checking bench for the one-wire bus master.
// ----------------------------------------------------------------------------
// A queue of tick transactions feeds a clocked driver. Each accepted tick runs
// through a cycle model of the bus sequencer, and the predicted result is
// queued. A clocked monitor compares every result field by field with the
// oldest prediction. Timing registers are rewritten between phases, only once
// the sequencer is idle and every result is back. The phases cover reset
// defaults, directed commands, all-zero timing, mixed extremes and random
// small timing. Both sides idle in short random bursts, and the result side
// holds off once for a long stretch. The last phases run without gaps.
// ----------------------------------------------------------------------------
module tb_one_wire_bus_master_top;
  import owb_pkg::*;

  localparam int ReadBits   = ReadBitsDef;
  localparam int ResLatency = 2;
  localparam int HoldCycles = 60;
  localparam int IdleLimit  = 1000;
  localparam int MaxPrints  = 50;
  localparam logic [1:0] FuncUnknown = 2'd3;

  logic             clk;
  logic             rst;
  logic             tick_valid = 1'b0;
  logic             tick_stall;
  tick_t            tick       = '0;
  logic             res_valid;
  logic             res_stall  = 1'b0;
  res_t             res;
  logic             cfg_valid  = 1'b0;
  logic             cfg_ready;
  reg_idx_t         cfg_index  = REG_RESET_LOW;
  logic [TimeW-1:0] cfg_data   = '0;

  one_wire_bus_master_top #(
    .READ_BITS(ReadBits)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .tick_valid(tick_valid),
    .tick_stall(tick_stall),
    .tick      (tick),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Sequencer model state
  cfg_t             bus_cfg;
  phase_t           ph;
  op_t              cur_op;
  logic [TimeW-1:0] tcount;
  logic [CntW-1:0]  bits_left;
  logic [DataW-1:0] shreg;
  logic             pres_flag;
  logic [DataW-1:0] held_word;

  tick_t tick_q[$];
  res_t  bus_exp_q[$];

  int ticks_pushed = 0;
  int ticks_taken  = 0;
  int results_seen = 0;
  int cmds_started = 0;
  int cmds_done    = 0;
  int cfg_writes   = 0;
  int err_count    = 0;
  int settings_run = 0;
  int gap_left     = 0;
  int stall_left   = 0;
  int hold_left    = 0;
  int hold_asked   = 0;
  int hold_served  = 0;
  int quiet_cycles = 0;
  int line_mode    = 2;  // 0 line low, 1 line high, 2 random
  bit idling       = 1'b1;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int at_least(int v, int m);
    return (v < m) ? m : v;
  endfunction

  task automatic report_err(string what, int got, int want);
    if (err_count < MaxPrints)
      $display("ERROR @%0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    err_count++;
  endtask

  // One microsecond of bus time
  task automatic step_bus(input tick_t t, output res_t r);
    int   len;
    int   low_len;
    int   samp_at;
    logic in_slot;
    logic slot_end;
    logic bit_in;
    r = '0;
    if (ph == PH_IDLE && t.start_req &&
        (t.func == OP_RESET || t.func == OP_WRITE || t.func == OP_READ)) begin
      cur_op = op_t'(t.func);
      tcount = '0;
      cmds_started++;
      case (cur_op)
        OP_RESET: begin
          ph        = PH_RST_LOW;
          pres_flag = 1'b0;
        end
        OP_WRITE: begin
          ph        = PH_SLOT;
          bits_left = CntW'(WRITE_BITS);
          shreg     = DataW'(t.write_byte);
        end
        default: begin
          ph        = PH_SLOT;
          bits_left = CntW'(ReadBits);
          shreg     = '0;
        end
      endcase
    end

    case (ph)
      PH_RST_LOW: begin
        r.busy_res  = 1'b1;
        r.drive_low = 1'b1;
        if (int'(tcount) + 1 >= at_least(int'(bus_cfg.reset_low_time), 1)) begin
          ph     = PH_RST_REL;
          tcount = '0;
        end else begin
          tcount++;
        end
      end
      PH_RST_REL: begin
        r.busy_res = 1'b1;
        // presence pulse: device pulls the line low
        if (tcount == bus_cfg.presence_sample_time)
          pres_flag = ~t.line_level;
        if (int'(tcount) + 1 >= at_least(int'(bus_cfg.reset_release_time), 1)) begin
          r.done_res = 1'b1;
          ph         = PH_IDLE;
          tcount     = '0;
        end else begin
          tcount++;
        end
      end
      PH_SLOT: begin
        len        = at_least(int'(bus_cfg.slot_length), 2);
        slot_end   = (int'(tcount) + 1 >= len);
        r.busy_res = 1'b1;
        if (cur_op == OP_WRITE)
          low_len = shreg[0] ? int'(bus_cfg.write_one_low_time)
                             : int'(bus_cfg.write_zero_low_time);
        else
          low_len = int'(bus_cfg.read_low_time);
        r.drive_low = (int'(tcount) < low_len);
        if (cur_op != OP_WRITE) begin
          // sample point past the slot end reads a zero on the last tick
          in_slot = (int'(bus_cfg.read_sample_time) < len);
          samp_at = in_slot ? int'(bus_cfg.read_sample_time) : len - 1;
          if (int'(tcount) == samp_at) begin
            bit_in = in_slot ? t.line_level : 1'b0;
            shreg  = {bit_in, shreg[DataW-1:1]};
          end
        end
        if (slot_end) begin
          if (cur_op == OP_WRITE)
            shreg = shreg >> 1;
          tcount = '0;
          if (bits_left <= 1) begin
            bits_left  = '0;
            r.done_res = 1'b1;
            ph         = PH_IDLE;
            if (cur_op != OP_WRITE)
              held_word = shreg >> (DataW - ReadBits);
          end else begin
            bits_left--;
          end
        end else begin
          tcount++;
        end
      end
      default: ;
    endcase
    r.presence  = pres_flag;
    r.read_word = held_word;
  endtask

  // Tick driver; predicts on acceptance
  always @(posedge clk) begin : tick_drv
    res_t pred;
    logic nxt_valid;
    if (rst) begin
      tick_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (tick_valid && !tick_stall) begin
        step_bus(tick, pred);
        bus_exp_q.push_back(pred);
        ticks_taken++;
      end
      if (!tick_valid || !tick_stall) begin
        nxt_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (idling && tick_q.size() > 0 && $urandom_range(0, 9) == 0) begin
          gap_left = $urandom_range(0, 3);
        end else if (tick_q.size() > 0) begin
          tick <= tick_q.pop_front();
          nxt_valid = 1'b1;
        end
        tick_valid <= nxt_valid;
      end
    end
  end

  // Result stall: random bursts plus the long hold-off on request
  always @(posedge clk) begin : res_stall_drv
    logic nxt;
    if (rst) begin
      res_stall <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (hold_served != hold_asked) begin
        hold_served = hold_asked;
        hold_left   = HoldCycles;
      end
      nxt = 1'b0;
      if (hold_left > 0) begin
        hold_left--;
        nxt = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        nxt = 1'b1;
      end else if (idling && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 3);
        nxt = 1'b1;
      end
      res_stall <= nxt;
    end
  end

  // Result monitor
  always @(posedge clk) begin : res_mon
    res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (bus_exp_q.size() == 0) begin
        report_err("result with no pending tick", int'(res), 0);
      end else begin
        want = bus_exp_q.pop_front();
        results_seen++;
        if (want.done_res)
          cmds_done++;
        if (res.drive_low !== want.drive_low)
          report_err("drive_low", res.drive_low, want.drive_low);
        if (res.busy_res !== want.busy_res)
          report_err("busy_res", res.busy_res, want.busy_res);
        if (res.done_res !== want.done_res)
          report_err("done_res", res.done_res, want.done_res);
        if (res.presence !== want.presence)
          report_err("presence", res.presence, want.presence);
        if (res.read_word !== want.read_word)
          report_err("read_word", res.read_word, want.read_word);
      end
    end
  end

  // Watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if ((tick_valid && !tick_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IdleLimit) begin
      $display("TIMEOUT: no transaction for %0d cycles", IdleLimit);
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic line_bit();
    return (line_mode == 2) ? 1'($urandom_range(0, 1)) : 1'(line_mode);
  endfunction

  task automatic push_tick(logic s, logic [1:0] f, logic [7:0] b, logic l);
    tick_t t;
    t.start_req  = s;
    t.func       = f;
    t.write_byte = b;
    t.line_level = l;
    tick_q.push_back(t);
    ticks_pushed++;
  endtask

  task automatic push_rand(int n, int start_pct);
    for (int i = 0; i < n; i++)
      push_tick($urandom_range(0, 99) < start_pct, 2'($urandom_range(0, 3)),
                8'($urandom), line_bit());
  endtask

  task automatic wait_taken();
    while (ticks_taken != ticks_pushed)
      @(posedge clk);
  endtask

  // Run the sequencer back to idle and collect every result
  task automatic drain();
    wait_taken();
    while (ph != PH_IDLE) begin
      repeat (16) push_tick(1'b0, OP_RESET, 8'($urandom), line_bit());
      wait_taken();
    end
    while (bus_exp_q.size() != 0)
      @(posedge clk);
    repeat (ResLatency + 3) @(posedge clk);
  endtask

  task automatic run_cmd(logic [1:0] f, logic [7:0] b, int lm);
    line_mode = lm;
    push_tick(1'b1, f, b, line_bit());
    drain();
  endtask

  task automatic write_reg(reg_idx_t idx, logic [TimeW-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_RESET_LOW:   bus_cfg.reset_low_time       = v;
      REG_RESET_REL:   bus_cfg.reset_release_time   = v;
      REG_PRES_SAMPLE: bus_cfg.presence_sample_time = v;
      REG_WR0_LOW:     bus_cfg.write_zero_low_time  = v;
      REG_WR1_LOW:     bus_cfg.write_one_low_time   = v;
      REG_RD_LOW:      bus_cfg.read_low_time        = v;
      REG_RD_SAMPLE:   bus_cfg.read_sample_time     = v;
      REG_SLOT_LEN:    bus_cfg.slot_length          = v;
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic apply_cfg(cfg_t c);
    write_reg(REG_RESET_LOW,   c.reset_low_time);
    write_reg(REG_RESET_REL,   c.reset_release_time);
    write_reg(REG_PRES_SAMPLE, c.presence_sample_time);
    write_reg(REG_WR0_LOW,     c.write_zero_low_time);
    write_reg(REG_WR1_LOW,     c.write_one_low_time);
    write_reg(REG_RD_LOW,      c.read_low_time);
    write_reg(REG_RD_SAMPLE,   c.read_sample_time);
    write_reg(REG_SLOT_LEN,    c.slot_length);
    settings_run++;
  endtask

  function automatic logic [TimeW-1:0] pick_time(bit allow_max);
    int r;
    r = $urandom_range(0, 19);
    if (r == 0)
      return '0;
    if (r == 1 && allow_max)
      return '1;
    return TimeW'($urandom_range(1, 12));
  endfunction

  // Small timing keeps commands short; only cheap fields may go to max
  function automatic cfg_t rand_cfg();
    cfg_t c;
    c.reset_low_time       = pick_time(1'b0);
    c.reset_release_time   = pick_time(1'b0);
    c.presence_sample_time = pick_time(1'b1);
    c.write_zero_low_time  = pick_time(1'b1);
    c.write_one_low_time   = pick_time(1'b1);
    c.read_low_time        = pick_time(1'b1);
    c.read_sample_time     = pick_time(1'b1);
    c.slot_length          = pick_time(1'b0);
    return c;
  endfunction

  initial begin : main_seq
    cfg_t c;
    bus_cfg   = {RstLowDef, RstRelDef, PresSampDef, Wr0LowDef,
                 Wr1LowDef, RdLowDef, RdSampDef, SlotLenDef};
    ph        = PH_IDLE;
    cur_op    = OP_RESET;
    tcount    = '0;
    bits_left = '0;
    shreg     = '0;
    pres_flag = 1'b0;
    held_word = '0;

    rst = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset-value timing, untouched registers; a byte write is the shortest
    run_cmd(OP_WRITE, 8'hA5, 2);

    // directed commands on short timing
    c = '{reset_low_time: 10'd3, reset_release_time: 10'd4, presence_sample_time: 10'd1,
          write_zero_low_time: 10'd2, write_one_low_time: 10'd1, read_low_time: 10'd1,
          read_sample_time: 10'd1, slot_length: 10'd3};
    apply_cfg(c);
    run_cmd(OP_RESET, 8'h00, 0);
    run_cmd(OP_RESET, 8'hFF, 1);
    run_cmd(OP_WRITE, 8'h00, 2);
    run_cmd(OP_WRITE, 8'hFF, 2);
    run_cmd(OP_WRITE, 8'hA5, 2);
    run_cmd(OP_READ,  8'h00, 0);
    run_cmd(OP_READ,  8'h00, 1);
    run_cmd(OP_READ,  8'h5A, 2);
    run_cmd(FuncUnknown, 8'hFF, 2);
    // starts while busy are dropped
    line_mode = 2;
    push_tick(1'b1, OP_RESET, 8'h00, 1'b0);
    push_tick(1'b1, OP_WRITE, 8'h3C, 1'b1);
    push_tick(1'b1, OP_READ,  8'hC3, 1'b0);
    drain();

    // everything zero: reset times and slot length clamp, no drive in the slots
    apply_cfg('0);
    push_rand(30, 30);
    drain();

    // mixed extremes: late presence sample, low time past slot, late read sample
    c = '{reset_low_time: 10'd0, reset_release_time: 10'd5, presence_sample_time: 10'h3FF,
          write_zero_low_time: 10'h3FF, write_one_low_time: 10'd0, read_low_time: 10'h3FF,
          read_sample_time: 10'h3FF, slot_length: 10'd4};
    apply_cfg(c);
    push_rand(30, 30);
    drain();

    c = '{reset_low_time: 10'd1, reset_release_time: 10'd1, presence_sample_time: 10'd0,
          write_zero_low_time: 10'd1, write_one_low_time: 10'h3FF, read_low_time: 10'd0,
          read_sample_time: 10'd3, slot_length: 10'd4};
    apply_cfg(c);
    push_rand(30, 30);
    drain();

    // random short timing
    for (int k = 0; k < 5; k++) begin
      if (k >= 3)
        idling = 1'b0;
      apply_cfg(rand_cfg());
      line_mode = 2;
      push_rand(15, 25);
      if (k == 1)
        hold_asked++;  // long result hold-off while ticks keep coming
      drain();
    end

    repeat (ResLatency + 4) @(posedge clk);
    while (bus_exp_q.size() != 0) begin
      report_err("missing result", 0, int'(bus_exp_q.pop_front()));
    end

    $display("Covered %0d ticks, %0d results, %0d commands started, %0d completed",
             ticks_taken, results_seen, cmds_started, cmds_done);
    $display("Timing settings applied: %0d (%0d register writes), errors: %0d",
             settings_run, cfg_writes, err_count);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
